// ----- hw/rtl/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and codes shared by the priority queue, its cells and its channels.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 6;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic                    insert;
    logic                    remove;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/mhpq_ifs.sv -----
// ----------------------------------------------------------------------------
// mhpq request and response channels
// Valid/ready channels that carry the queue requests and their results.
// ----------------------------------------------------------------------------
interface mhpq_req_if import mhpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [KEY_W-1:0]   top_key;
  logic                      top_valid;
  logic [COUNT_W-1:0]        count;
  logic signed [KEY_W-1:0]   removed_key;
  logic [1:0]                status;

  modport source (output valid, output top_key, output top_valid, output count,
                  output removed_key, output status, input ready);
  modport sink (input valid, input top_key, input top_valid, input count,
                input removed_key, input status, output ready);
endinterface

// ----- hw/rtl/max_heap_priority_queue.sv -----
// A result is presented in the cycle after its request is accepted. Requests
// are taken one per cycle while no result waits untaken; each cell of the
// sorted row does one compare and one shift step per request, so the row size
// does not set the rate. A waiting result does not block the next request while
// the sink takes it. Reset empties the queue and drops any waiting result.
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Bounded max-priority queue of signed keys built as a sorted row of cells.
// ----------------------------------------------------------------------------
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  cell_cmd_t             cmd;
  slot_t                 cell_slot [CAPACITY];
  slot_t                 cell_next [CAPACITY];
  logic [CAPACITY-1:0]   cell_ge;
  logic [CAPACITY-1:0]   valid_vec;
  logic [CW-1:0]         held;
  logic [CW-1:0]         held_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  want_insert;
  logic                  want_remove;
  status_t               status_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (held == CW'(CAPACITY));
  assign empty     = !cell_slot[0].valid;

  always_comb begin
    want_insert = 1'b0;
    want_remove = 1'b0;
    unique case (req.mode)
      MODE_INSERT: want_insert = 1'b1;
      MODE_REMOVE: want_remove = 1'b1;
      default:     ;
    endcase
  end

  always_comb begin
    cmd.insert  = accept && want_insert && !full;
    cmd.remove  = accept && want_remove && !empty;
    cmd.key     = req.key;
    status_next = STATUS_DONE;
    if (want_insert && full) begin
      status_next = STATUS_FULL;
    end else if (want_remove && empty) begin
      status_next = STATUS_EMPTY;
    end
    held_next = held;
    if (cmd.insert) begin
      held_next = held + CW'(1);
    end else if (cmd.remove) begin
      held_next = held - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_ge;

    if (i == 0) begin : g_head
      assign left_slot = '0;
      assign left_ge   = 1'b1;
    end else begin : g_body
      assign left_slot = cell_slot[i-1];
      assign left_ge   = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_link
      assign right_slot = cell_slot[i+1];
    end

    mhpq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left_slot  (left_slot),
      .left_ge    (left_ge),
      .right_slot (right_slot),
      .slot       (cell_slot[i]),
      .slot_next  (cell_next[i]),
      .ge         (cell_ge[i])
    );

    assign valid_vec[i] = cell_slot[i].valid;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.top_key     <= cell_next[0].valid ? cell_next[0].key : '0;
      rsp.top_valid   <= cell_next[0].valid;
      rsp.count       <= COUNT_W'(held_next);
      rsp.removed_key <= cmd.remove ? cell_slot[0].key : '0;
      rsp.status      <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      held <= held_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  logic [CAPACITY:0] valid_plus;
  assign valid_plus = (CAPACITY + 1)'({1'b0, valid_vec}) + (CAPACITY + 1)'(1);

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot(valid_plus))
    else $error("Occupied cells do not form a prefix of the row.");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    held == CW'($countones(valid_vec)))
    else $error("Held count disagrees with occupied cells.");

  a_head_is_max: assert property (@(posedge clk) disable iff (rst)
    cell_slot[1].valid |-> !(cell_slot[0].key < cell_slot[1].key))
    else $error("Head cell does not hold the largest key.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("Accepted request produced no result.");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == STATUS_EMPTY |-> !rsp.top_valid && rsp.removed_key == '0)
    else $error("Removal from empty queue reported a key.");

endmodule

// ----- hw/rtl/mhpq_cell.sv -----
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted key row; keeps, takes or shifts a key each cycle.
// ----------------------------------------------------------------------------
module mhpq_cell import mhpq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  slot_t     left_slot,
  input  logic      left_ge,
  input  slot_t     right_slot,
  output slot_t     slot,
  output slot_t     slot_next,
  output logic      ge
);

  assign ge = slot.valid && !(slot.key < cmd.key);

  always_comb begin
    slot_next = slot;
    if (cmd.insert) begin
      if (!ge) begin
        if (left_ge) begin
          slot_next.valid = 1'b1;
          slot_next.key   = cmd.key;
        end else begin
          slot_next = left_slot;
        end
      end
    end else if (cmd.remove) begin
      slot_next = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot.key <= slot_next.key;
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
  end

endmodule
